[src/lcc_pkg.sv]
// Shared types, constants and helpers of the latency clock trim controller.
// Used by every module of the block but lcc_ram; depends on nothing.

package lcc_pkg;

  // Field widths
  localparam int TS_W      = 33;   // pts / stc, 90 kHz ticks
  localparam int MS_W      = 27;   // latency and average in ms
  localparam int TGT_W     = 28;   // latched target
  localparam int LVL_W     = 3;
  localparam int SCALE_W   = 17;
  localparam int JUMP_W    = 16;
  localparam int COUNT_W   = 10;   // signed preroll / fill count
  localparam int PROD_W    = TGT_W + 4;
  localparam int AVG7_W    = MS_W + 3;

  localparam int IN_DATA_W  = 72;  // 67 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 112; // 106 bits of fields, padded to bytes

  // Parameter defaults
  localparam int WINDOW_SIZE_DEF = 8;
  localparam int PREROLL_DEF     = 16;

  localparam logic [JUMP_W-1:0] JUMP_MAX = {JUMP_W{1'b1}};

  // Shared divider: restoring, DIV_STEPS quotient bits per cycle
  localparam int DIV_BITS    = 36;
  localparam int DIV_STEPS   = 6;
  localparam int DIV_CYCLES  = DIV_BITS / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);
  localparam int DIV_DEN_W   = 7;
  localparam int TICKS_PER_MS = 90;
  localparam int TGT_MULT     = 7;   // 1.4 = 7 / 5
  localparam int TGT_DIVISOR  = 5;

  // Commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

  // Correction levels
  localparam logic [LVL_W-1:0] LVL_MAX_SLOW = 3'd0;
  localparam logic [LVL_W-1:0] LVL_SLOW     = 3'd1;
  localparam logic [LVL_W-1:0] LVL_NONE     = 3'd2;
  localparam logic [LVL_W-1:0] LVL_FAST     = 3'd3;
  localparam logic [LVL_W-1:0] LVL_MAX_FAST = 3'd4;

  typedef enum logic [1:0] {
    DIV_SEL_LAT,
    DIV_SEL_AVG,
    DIV_SEL_TGT
  } div_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    logic     do_reset;
    logic     div_start;
    div_sel_t div_sel;
    logic     win_update;
    logic     cnt_inc;
    logic     avg_load;
    logic     tgt_load;
    logic     band_mul;
    logic     band_cmp;
    logic     level_upd;
    logic     emit;
    logic     emit_valid;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_reset_cmd;
    logic ignore;
    logic fill_pending;
    logic target_zero;
    logic div_done;
    logic out_free;
  } stat_t;

  // Q16 clock scale of each correction level
  function automatic logic [SCALE_W-1:0] scale_of(input logic [LVL_W-1:0] lvl);
    logic [SCALE_W-1:0] s;
    unique case (lvl)
      LVL_MAX_SLOW: s = 17'd65470;
      LVL_SLOW:     s = 17'd65526;
      LVL_FAST:     s = 17'd65545;
      LVL_MAX_FAST: s = 17'd65601;
      default:      s = 17'd65536;
    endcase
    return s;
  endfunction

endpackage

[src/latency_clock_trim_controller.sv]
// Top level of the latency clock trim controller: stream ports, controller
// and datapath. Depends on lcc_pkg, lcc_ctrl and lcc_datapath.

// The block takes one item at a time and returns exactly one result item for
// each. A reset command or an ignored sample (zero pts, zero stc, stopped clock,
// or pts not ahead of stc) goes from the check straight to the result step.
// A usable sample converts pts-stc to milliseconds in the shared divider
// (six quotient bits per cycle), replaces the oldest window entry and
// updates a running window sum; while the window fills or the preroll runs
// it then goes to the result. A decision adds a second divider pass for the
// window average, while the target is zero a third pass for 7*avg/5 that
// latches the target, and then band multiply, compare and level steps.
// The result sits in an output register, so the next item is accepted while
// a result still waits; a stalled output only holds the controller at its
// last step. No clearing pass follows rst_n: window entries not yet written
// count as zero.

module latency_clock_trim_controller import lcc_pkg::*; #(
  parameter int WINDOW_SIZE     = WINDOW_SIZE_DEF,
  parameter int PREROLL_SAMPLES = PREROLL_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pts[32:0], stc[65:33], clock_running[66]
  input  logic [0:0]            in_tuser,   // command[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // correction[2:0], clock_scale[19:3],
                                            // average_ms[46:20], target_ms[73:47],
                                            // fast_jumps[89:74], slow_jumps[105:90]
  output logic [0:0]            out_tuser   // scale_valid[0]
);

  ctrl_t ctrl;
  stat_t stat;

  logic [LVL_W-1:0]   correction;
  logic [SCALE_W-1:0] clock_scale;
  logic [MS_W-1:0]    average_ms;
  logic [MS_W-1:0]    target_ms;
  logic [JUMP_W-1:0]  fast_jumps;
  logic [JUMP_W-1:0]  slow_jumps;
  logic               scale_valid;

  // Sequence each item: check, convert, window update, average, target while zero, bands, emit
  lcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  lcc_datapath #(
    .WINDOW_SIZE     (WINDOW_SIZE),
    .PREROLL_SAMPLES (PREROLL_SAMPLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_tuser[0]),
    .in_pts           (in_tdata[TS_W-1:0]),
    .in_stc           (in_tdata[2*TS_W-1:TS_W]),
    .in_clock_running (in_tdata[2*TS_W]),
    .ctrl             (ctrl),
    .stat             (stat),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_scale_valid  (scale_valid),
    .out_correction   (correction),
    .out_clock_scale  (clock_scale),
    .out_average_ms   (average_ms),
    .out_target_ms    (target_ms),
    .out_fast_jumps   (fast_jumps),
    .out_slow_jumps   (slow_jumps)
  );

  // Pack result fields from the lowest bit up; pad to whole bytes
  assign out_tdata = {6'b000000, slow_jumps, fast_jumps, target_ms, average_ms,
                      clock_scale, correction};
  assign out_tuser = scale_valid;

  // One item at a time: acceptance drops ready until the result is built
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is still in work");

  // A result without a decision carries a zero average
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !scale_valid |-> average_ms == '0)
    else $error("average shown without a decision");

  // Scale always belongs to the reported level
  a_scale_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> clock_scale == scale_of(correction))
    else $error("clock scale does not match correction level");

  // The divider is never restarted while the controller waits on it
  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.div_start |=> !ctrl.div_start && !stat.div_done)
    else $error("divider restarted or finished too early");

endmodule

[src/lcc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module lcc_ram #(
  parameter int WIDTH  = 27,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/lcc_div.sv]
// Shared multi-cycle restoring divider, DIV_STEPS quotient bits per cycle.
// Depends on lcc_pkg.

module lcc_div import lcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_BITS-1:0]  dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_BITS-1:0]  quotient
);

  logic [DIV_BITS-1:0]  dvd_r, dvd_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // Shift one dividend bit into the remainder per step; quotient bits
  // fill the dividend register from the bottom.
  always_comb begin
    logic [DIV_DEN_W:0] part;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      part = {rem_nxt, dvd_nxt[DIV_BITS-1]};
      if (part >= {1'b0, den_r}) begin
        rem_nxt = DIV_DEN_W'(part - {1'b0, den_r});
        dvd_nxt = {dvd_nxt[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = part[DIV_DEN_W-1:0];
        dvd_nxt = {dvd_nxt[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_CYCLES);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

[src/lcc_datapath.sv]
// Datapath of the trim controller: latency window, running sum, target,
// band compares, level and jump counters, result register.
// Depends on lcc_pkg, lcc_ram and lcc_div.

module lcc_datapath import lcc_pkg::*; #(
  parameter int WINDOW_SIZE     = WINDOW_SIZE_DEF,
  parameter int PREROLL_SAMPLES = PREROLL_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_command,
  input  logic [TS_W-1:0]   in_pts,
  input  logic [TS_W-1:0]   in_stc,
  input  logic              in_clock_running,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_scale_valid,
  output logic [LVL_W-1:0]  out_correction,
  output logic [SCALE_W-1:0] out_clock_scale,
  output logic [MS_W-1:0]   out_average_ms,
  output logic [MS_W-1:0]   out_target_ms,
  output logic [JUMP_W-1:0] out_fast_jumps,
  output logic [JUMP_W-1:0] out_slow_jumps
);

  localparam int AW    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int SUM_W = MS_W + $clog2(WINDOW_SIZE);

  // Captured item
  logic            cmd_r;
  logic [TS_W-1:0] pts_r, stc_r;
  logic            run_r;

  // Window state
  logic [AW-1:0]            wptr_r;
  logic                     wrapped_r;
  logic [SUM_W-1:0]         sum_r;
  logic signed [COUNT_W-1:0] count_r;

  // Decision state
  logic [MS_W-1:0]   avg_r;
  logic [TGT_W-1:0]  target_r;
  logic [LVL_W-1:0]  level_r;
  logic [JUMP_W-1:0] fast_r, slow_r;
  logic [PROD_W-1:0] a10_r, t11_r, t9_r;
  logic gt2_r, lth_r, gt11_r, lt9_r, gtt_r, ltt_r;

  // Result register
  logic              out_valid_r;
  logic              res_valid_r;
  logic [LVL_W-1:0]  res_lvl_r;
  logic [SCALE_W-1:0] res_scale_r;
  logic [MS_W-1:0]   res_avg_r, res_tgt_r;
  logic [JUMP_W-1:0] res_fast_r, res_slow_r;

  logic [TS_W-1:0]      diff;
  logic [MS_W-1:0]      lat;
  logic [MS_W-1:0]      rd_data;
  logic [MS_W-1:0]      old;
  logic [AVG7_W-1:0]    avg7;
  logic [DIV_BITS-1:0]  div_dividend;
  logic [DIV_DEN_W-1:0] div_divisor;
  logic [DIV_BITS-1:0]  div_q;
  logic                 div_done;

  assign diff = pts_r - stc_r;
  assign lat  = div_q[MS_W-1:0];
  assign old  = wrapped_r ? rd_data : '0;
  assign avg7 = {avg_r, 3'b000} - {3'b000, avg_r};

  always_comb begin
    unique case (ctrl.div_sel)
      DIV_SEL_LAT: begin
        div_dividend = DIV_BITS'(diff);
        div_divisor  = DIV_DEN_W'(TICKS_PER_MS);
      end
      DIV_SEL_AVG: begin
        div_dividend = DIV_BITS'(sum_r);
        div_divisor  = DIV_DEN_W'(WINDOW_SIZE);
      end
      DIV_SEL_TGT: begin
        div_dividend = DIV_BITS'(avg7);
        div_divisor  = DIV_DEN_W'(TGT_DIVISOR);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DIV_DEN_W'(TICKS_PER_MS);
      end
    endcase
  end

  lcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  lcc_ram #(
    .WIDTH (MS_W),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (ctrl.win_update),
    .waddr (wptr_r),
    .wdata (lat),
    .raddr (wptr_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r <= in_command;
      pts_r <= in_pts;
      stc_r <= in_stc;
      run_r <= in_clock_running;
    end
  end

  // Window ring, running sum and fill count. Entries not yet written
  // read as zero, which is what the wrapped flag tracks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r    <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
      count_r   <= '0;
    end else begin
      if (ctrl.win_update) begin
        sum_r <= sum_r + SUM_W'(lat) - SUM_W'(old);
        if (wptr_r == AW'(WINDOW_SIZE - 1)) begin
          wptr_r    <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wptr_r <= wptr_r + 1'b1;
        end
      end
      if (ctrl.do_reset) begin
        count_r <= COUNT_W'(0) - COUNT_W'(PREROLL_SAMPLES);
      end else if (ctrl.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.avg_load) begin
      avg_r <= div_q[MS_W-1:0];
    end
    if (ctrl.band_mul) begin
      a10_r <= PROD_W'({avg_r, 3'b000}) + PROD_W'({avg_r, 1'b0});
      t11_r <= PROD_W'({target_r, 3'b000}) + PROD_W'({target_r, 1'b0}) + PROD_W'(target_r);
      t9_r  <= PROD_W'({target_r, 3'b000}) + PROD_W'(target_r);
    end
    if (ctrl.band_cmp) begin
      gt2_r  <= {2'b00, avg_r} > {1'b0, target_r, 1'b0};
      lth_r  <= {avg_r, 1'b0} < target_r;
      gt11_r <= a10_r > t11_r;
      lt9_r  <= a10_r < t9_r;
      gtt_r  <= {1'b0, avg_r} > target_r;
      ltt_r  <= {1'b0, avg_r} < target_r;
    end
  end

  // Target, level and jump counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      level_r  <= LVL_NONE;
      fast_r   <= '0;
      slow_r   <= '0;
    end else if (ctrl.do_reset) begin
      target_r <= '0;
      level_r  <= LVL_NONE;
      fast_r   <= '0;
      slow_r   <= '0;
    end else begin
      if (ctrl.tgt_load) begin
        target_r <= div_q[TGT_W-1:0];
      end
      if (ctrl.level_upd) begin
        priority if (gt2_r) begin
          if (level_r < LVL_MAX_FAST) begin
            level_r <= LVL_MAX_FAST;
            if (fast_r != JUMP_MAX) fast_r <= fast_r + 1'b1;
          end
        end else if (lth_r) begin
          if (level_r > LVL_MAX_SLOW) begin
            level_r <= LVL_MAX_SLOW;
            if (slow_r != JUMP_MAX) slow_r <= slow_r + 1'b1;
          end
        end else if (gt11_r) begin
          if (level_r < LVL_MAX_FAST) level_r <= LVL_FAST;
        end else if (lt9_r) begin
          if (level_r > LVL_MAX_SLOW) level_r <= LVL_SLOW;
        end else if (gtt_r) begin
          if (level_r < LVL_NONE) level_r <= LVL_NONE;
        end else if (ltt_r) begin
          if (level_r > LVL_NONE) level_r <= LVL_NONE;
        end else begin
          level_r <= LVL_NONE;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      res_valid_r <= ctrl.emit_valid;
      res_lvl_r   <= level_r;
      res_scale_r <= scale_of(level_r);
      res_avg_r   <= ctrl.emit_valid ? avg_r : '0;
      res_tgt_r   <= target_r[MS_W-1:0];
      res_fast_r  <= fast_r;
      res_slow_r  <= slow_r;
    end
  end

  assign stat.is_reset_cmd = (cmd_r == CMD_RESET);
  assign stat.ignore       = (pts_r == '0) || !run_r || (stc_r == '0) || (pts_r <= stc_r);
  assign stat.fill_pending = count_r < $signed(COUNT_W'(WINDOW_SIZE - 1));
  assign stat.target_zero  = (target_r == '0);
  assign stat.div_done     = div_done;
  assign stat.out_free     = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_scale_valid = res_valid_r;
  assign out_correction  = res_lvl_r;
  assign out_clock_scale = res_scale_r;
  assign out_average_ms  = res_avg_r;
  assign out_target_ms   = res_tgt_r;
  assign out_fast_jumps  = res_fast_r;
  assign out_slow_jumps  = res_slow_r;

endmodule

[src/lcc_ctrl.sv]
// Sequencing state machine of the trim controller.
// Depends on lcc_pkg; drives the datapath through ctrl_t, reads stat_t.

module lcc_ctrl import lcc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_LAT,
    S_WRITE,
    S_AVG_START,
    S_DIV_AVG,
    S_TGT_START,
    S_DIV_TGT,
    S_BAND_MUL,
    S_BAND_CMP,
    S_LEVEL,
    S_EMIT,
    S_EMIT_DEC
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    ctrl      = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_reset_cmd) begin
          ctrl.do_reset = 1'b1;
          state_nxt     = S_EMIT;
        end else if (stat.ignore) begin
          state_nxt = S_EMIT;
        end else begin
          ctrl.div_start = 1'b1;
          ctrl.div_sel   = DIV_SEL_LAT;
          state_nxt      = S_DIV_LAT;
        end
      end
      S_DIV_LAT: begin
        if (stat.div_done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        ctrl.win_update = 1'b1;
        if (stat.fill_pending) begin
          ctrl.cnt_inc = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_AVG_START;
        end
      end
      S_AVG_START: begin
        ctrl.div_start = 1'b1;
        ctrl.div_sel   = DIV_SEL_AVG;
        state_nxt      = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        if (stat.div_done) begin
          ctrl.avg_load = 1'b1;
          state_nxt     = stat.target_zero ? S_TGT_START : S_BAND_MUL;
        end
      end
      S_TGT_START: begin
        ctrl.div_start = 1'b1;
        ctrl.div_sel   = DIV_SEL_TGT;
        state_nxt      = S_DIV_TGT;
      end
      S_DIV_TGT: begin
        if (stat.div_done) begin
          ctrl.tgt_load = 1'b1;
          state_nxt     = S_BAND_MUL;
        end
      end
      S_BAND_MUL: begin
        ctrl.band_mul = 1'b1;
        state_nxt     = S_BAND_CMP;
      end
      S_BAND_CMP: begin
        ctrl.band_cmp = 1'b1;
        state_nxt     = S_LEVEL;
      end
      S_LEVEL: begin
        ctrl.level_upd = 1'b1;
        state_nxt      = S_EMIT_DEC;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctrl.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_DEC: begin
        if (stat.out_free) begin
          ctrl.emit       = 1'b1;
          ctrl.emit_valid = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
